// ===== hdl/gav_pkg.sv =====
`default_nettype none
// ============================================================================
// gav_pkg
// Shared types, constants and tables for the goal approach velocity command.
// ============================================================================
package gav_pkg;

  localparam int FracBits     = 8;
  localparam int CordicStages = 16;
  localparam int NumRegs      = 8;
  localparam int AngW         = 20;   // radians, 16 fraction bits, covers +-pi
  localparam int CorW         = 34;   // prescaled CORDIC x/y width
  localparam int SqW          = 33;   // x*x+y*y
  localparam int RootW        = 17;   // planar distance

  localparam logic signed [AngW-1:0] AnglePi = 20'sd205887;

  // Register indexes.
  localparam logic [2:0] RegHeight   = 3'd0;
  localparam logic [2:0] RegArrival  = 3'd1;
  localparam logic [2:0] RegClimb    = 3'd2;
  localparam logic [2:0] RegYawGain  = 3'd3;
  localparam logic [2:0] RegYawLimit = 3'd4;
  localparam logic [2:0] RegFacing   = 3'd5;
  localparam logic [2:0] RegFwdGain  = 3'd6;
  localparam logic [2:0] RegFwdLimit = 3'd7;

  typedef struct packed {
    logic signed [15:0] rel_x;
    logic signed [15:0] rel_y;
    logic signed [15:0] rel_z;
    logic               position_valid;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] climb_rate;
    logic signed [15:0] yaw_rate;
    logic [14:0]        forward_speed;
    logic               arrived;
  } out_beat_t;

  typedef struct packed {
    logic [14:0] height_threshold;
    logic [14:0] arrival_threshold;
    logic [14:0] climb_speed;
    logic [14:0] yaw_gain;
    logic [14:0] yaw_limit;
    logic [14:0] facing_limit;
    logic [14:0] forward_gain;
    logic [14:0] forward_limit;
  } cfg_t;

  // Per-item side information carried down the pipeline.
  typedef enum logic [2:0] {
    MODE_LEVEL = 3'b001,
    MODE_UP    = 3'b010,
    MODE_DOWN  = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic        zero_cmd;   // height error exactly on the band edge
    logic        arrived;
  } side_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic signed [AngW-1:0] t;
    case (i)
      0: t = 20'sd51472;  1: t = 20'sd30386;  2: t = 20'sd16055;  3: t = 20'sd8150;
      4: t = 20'sd4091;   5: t = 20'sd2047;   6: t = 20'sd1024;   7: t = 20'sd512;
      8: t = 20'sd256;    9: t = 20'sd128;   10: t = 20'sd64;    11: t = 20'sd32;
      12: t = 20'sd16;   13: t = 20'sd8;     14: t = 20'sd4;     15: t = 20'sd2;
      16: t = 20'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/gav_cfg_regs.sv =====
`default_nettype none
// ============================================================================
// gav_cfg_regs
// Configuration register file written through the index/data port.
// ============================================================================
module gav_cfg_regs
  import gav_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  output logic             cfg_ready,
  output cfg_t             cfg
);

  cfg_t regs_r;

  assign cfg_ready = 1'b1;
  assign cfg       = regs_r;

  // Register writes, one per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.height_threshold  <= 15'd26;
      regs_r.arrival_threshold <= 15'd51;
      regs_r.climb_speed       <= 15'd77;
      regs_r.yaw_gain          <= 15'd768;
      regs_r.yaw_limit         <= 15'd256;
      regs_r.facing_limit      <= 15'd77;
      regs_r.forward_gain      <= 15'd102;
      regs_r.forward_limit     <= 15'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegHeight:   regs_r.height_threshold  <= cfg_data;
        RegArrival:  regs_r.arrival_threshold <= cfg_data;
        RegClimb:    regs_r.climb_speed       <= cfg_data;
        RegYawGain:  regs_r.yaw_gain          <= cfg_data;
        RegYawLimit: regs_r.yaw_limit         <= cfg_data;
        RegFacing:   regs_r.facing_limit      <= cfg_data;
        RegFwdGain:  regs_r.forward_gain      <= cfg_data;
        RegFwdLimit: regs_r.forward_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gav_cordic.sv =====
`default_nettype none
// ============================================================================
// gav_cordic
// Pipelined CORDIC vectoring unit: one stage per iteration, giving atan2(y,x)
// in radians with 16 fraction bits.
// ============================================================================
module gav_cordic
  import gav_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   adv,
  input  wire logic signed [15:0]     x_in,
  input  wire logic signed [15:0]     y_in,
  output logic signed [AngW-1:0]      ang_out
);

  logic signed [CorW-1:0] x_r [CordicStages+1];
  logic signed [CorW-1:0] y_r [CordicStages+1];
  logic signed [AngW-1:0] z_r [CordicStages+1];
  logic                   zero_r [CordicStages+1];

  logic signed [CorW-1:0] x0_nxt, y0_nxt;
  logic signed [AngW-1:0] z0_nxt;

  // Pre-rotation into the right half plane and prescale.
  always_comb begin
    z0_nxt = '0;
    x0_nxt = CorW'(x_in) <<< 14;
    y0_nxt = CorW'(y_in) <<< 14;
    if (x_in < 0) begin
      z0_nxt = (y_in >= 0) ? AnglePi : -AnglePi;
      x0_nxt = -x0_nxt;
      y0_nxt = -y0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      zero_r[0] <= (x_in == 0) && (y_in == 0);
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end
      end
    end
  end

  assign ang_out = zero_r[CordicStages] ? '0 : z_r[CordicStages];

endmodule
`default_nettype wire

// ===== hdl/gav_isqrt.sv =====
`default_nettype none
// ============================================================================
// gav_isqrt
// Pipelined restoring integer square root, one result bit per stage.
// ============================================================================
module gav_isqrt
  import gav_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire logic [SqW-1:0]    sq_in,
  output logic [RootW-1:0]       root_out
);

  localparam int Steps = RootW;
  localparam int RemW  = SqW + 2;

  logic [RemW-1:0]  rem_r  [Steps+1];
  logic [RootW-1:0] root_r [Steps+1];
  logic [2*Steps-1:0] val_r [Steps+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      val_r[0]  <= (2*Steps)'(sq_in);
    end
  end

  // Each stage brings in two radicand bits and decides one root bit.
  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [RemW-1:0] rem_sh, trial;
    assign rem_sh = {rem_r[i][RemW-3:0], val_r[i][2*Steps-1 -: 2]};
    assign trial  = {rem_r[i][RemW-3:0] & '0, 2'b00} |
                    RemW'({root_r[i], 2'b01});
    always_ff @(posedge clk) begin
      if (adv) begin
        val_r[i+1] <= val_r[i] << 2;
        if (rem_sh >= trial) begin
          rem_r[i+1]  <= rem_sh - trial;
          root_r[i+1] <= {root_r[i][RootW-2:0], 1'b1};
        end else begin
          rem_r[i+1]  <= rem_sh;
          root_r[i+1] <= {root_r[i][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_out = root_r[Steps];

endmodule
`default_nettype wire

// ===== hdl/goal_approach_velocity_command_unit.sv =====
`default_nettype none
// ============================================================================
// goal_approach_velocity_command_unit
// Turns a goal position relative to the vehicle into one velocity command.
// ============================================================================
// Usage:
//   The input channel takes one position beat per cycle (in_valid high and
//   in_stall low). Beats with position_valid low produce no result.
//   Each valid beat yields one command beat on the out channel.
//   An accepted input beat passes through 17 CORDIC stages (entry plus 16
//   rotations) for the bearing, then yaw gain, yaw clamp, forward gain and
//   output stages. The planar square root (entry plus 17 bit stages) runs in
//   parallel with the CORDIC. Throughput is one beat per cycle while
//   out_stall does not hold a valid result.
//   The whole pipeline advances together; when out_stall holds a valid
//   result, in_stall is raised and every stage holds its contents, so
//   nothing is lost or repeated.
//   Configuration writes use cfg_valid/cfg_ready (always ready) with a
//   register index and 15-bit data; indexes beyond 7 are ignored.
//   Synchronous reset (rst_n low) empties the pipeline and restores the
//   register defaults.
// ============================================================================
module goal_approach_velocity_command_unit
  import gav_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  localparam int CorLat = CordicStages + 1;
  localparam int Depth  = CorLat + 4;

  cfg_t cfg;
  logic adv;

  gav_cfg_regs u_regs (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .cfg_ready, .cfg
  );

  // Whole-pipeline advance: stop only when the output holds an untaken beat.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Entry stage: band decision, squares, arrival.
  logic signed [15:0] ax, ay, az;
  logic [30:0] xx, yy, zz;
  logic [SqW-1:0] pl_sq;
  logic [33:0] d3;
  logic [29:0] thr;
  side_t side0;
  logic signed [16:0] zs, hs;

  always_comb begin
    ax = in_data.rel_x; ay = in_data.rel_y; az = in_data.rel_z;
    xx = 31'(ax * ax);
    yy = 31'(ay * ay);
    zz = 31'(az * az);
    pl_sq = SqW'(xx) + SqW'(yy);
    d3 = 34'(pl_sq) + 34'(zz);
    thr = cfg.arrival_threshold * cfg.arrival_threshold;
    zs = 17'(az);
    hs = {2'b00, cfg.height_threshold};
    if (zs > hs)       side0.mode = MODE_UP;
    else if (zs < -hs) side0.mode = MODE_DOWN;
    else               side0.mode = MODE_LEVEL;
    side0.zero_cmd = (zs == hs) || (zs == -hs);
    side0.arrived  = d3 <= 34'(thr);
  end

  logic [Depth-1:0] vld_r;
  side_t side_r [Depth];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Depth-2:0], in_valid && in_data.position_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side0;
      for (int i = 1; i < Depth; i++) side_r[i] <= side_r[i-1];
    end
  end

  // Bearing and planar distance, in parallel.
  logic signed [AngW-1:0] ang;
  logic [RootW-1:0] planar;

  gav_cordic u_cordic (.clk, .adv, .x_in(in_data.rel_x), .y_in(in_data.rel_y),
                       .ang_out(ang));
  gav_isqrt u_sqrt (.clk, .adv, .sq_in(pl_sq), .root_out(planar));

  // Yaw gain stage; the square root ends one stage after the CORDIC.
  logic [AngW-1:0] mag;
  logic [34:0] ymul_r;
  logic        yneg_r;
  logic [RootW-1:0] planar_r;
  assign mag = ang[AngW-1] ? AngW'(-ang) : AngW'(ang);

  always_ff @(posedge clk) begin
    if (adv) begin
      ymul_r   <= 35'(mag) * 35'(cfg.yaw_gain) + 35'd32768;
      yneg_r   <= ang[AngW-1];
      planar_r <= planar;
    end
  end

  // Yaw clamp stage.
  logic [18:0] ymag;
  logic [14:0] yclamp;
  logic [14:0] yaw_abs_r;
  logic        yaw_neg_r;
  assign ymag   = ymul_r[34:16];
  assign yclamp = (ymag > 19'(cfg.yaw_limit)) ? cfg.yaw_limit : ymag[14:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_abs_r <= yclamp;
      yaw_neg_r <= yneg_r && (yclamp != '0);
    end
  end

  // Forward gain stage.
  logic [32:0] fmul_r;
  logic [14:0] yaw_abs2_r;
  logic        yaw_neg2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      fmul_r     <= 33'(planar_r) * 33'(cfg.forward_gain) +
                    33'(1 << (FracBits - 1));
      yaw_abs2_r <= yaw_abs_r;
      yaw_neg2_r <= yaw_neg_r;
    end
  end

  // Output stage: cap, facing test and band selection.
  logic [24:0] fsh;
  logic [14:0] fcap;
  side_t sd;
  out_beat_t res;
  assign fsh  = 25'(fmul_r >> FracBits);
  assign fcap = (fsh > 25'(cfg.forward_limit)) ? cfg.forward_limit : fsh[14:0];
  assign sd   = side_r[Depth-2];

  always_comb begin
    res = '0;
    res.arrived = sd.arrived;
    case (sd.mode)
      MODE_UP:   res.climb_rate = 16'(cfg.climb_speed);
      MODE_DOWN: res.climb_rate = -16'(cfg.climb_speed);
      default: begin
        if (!sd.zero_cmd) begin
          res.yaw_rate = yaw_neg2_r ? -16'(yaw_abs2_r) : 16'(yaw_abs2_r);
          if (yaw_abs2_r < cfg.facing_limit) res.forward_speed = fcap;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= res;
  end

  assign out_valid = vld_r[Depth-1];

endmodule
`default_nettype wire
